// ----- rtl/sis_pkg.sv -----
`timescale 1ns / 1ps

package sis_pkg;

   localparam int CFG_W           = 11;
   localparam int RAND_W          = 32;
   localparam int INDEX_OUT_W     = 10;
   localparam int SUBSET_W        = 2;
   localparam int CSR_INDEX_W     = 2;
   localparam int DIGIT_BITS      = 4;
   localparam int EPOCH_W         = 8;
   localparam int DEF_MAX_RECORDS = 1024;
   localparam int DEF_RANDOM_BITS = 32;

   localparam logic [CFG_W-1:0] RESET_RECORD_COUNT = 11'd1024;
   localparam logic [CFG_W-1:0] RESET_FIRST_SIZE   = 11'd1024;
   localparam logic [CFG_W-1:0] RESET_SECOND_SIZE  = 11'd0;
   localparam logic [CFG_W-1:0] RESET_THIRD_SIZE   = 11'd0;

   localparam logic [CSR_INDEX_W-1:0] REG_RECORD_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_SIZE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_SIZE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_THIRD_SIZE   = 2'd3;

   localparam logic [SUBSET_W-1:0] SUBSET_FIRST   = 2'd0;
   localparam logic [SUBSET_W-1:0] SUBSET_SECOND  = 2'd1;
   localparam logic [SUBSET_W-1:0] SUBSET_THIRD   = 2'd2;
   localparam logic [SUBSET_W-1:0] SUBSET_DROPPED = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ_K,
      ST_READ_J,
      ST_WRITE_K,
      ST_WRITE_J,
      ST_READ_LAST
   } state_type;

endpackage

// ----- rtl/sis_mod_unit.sv -----
`timescale 1ns / 1ps

module sis_mod_unit #(
   parameter int DRAW_W = 32,
   parameter int DIV_W  = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DRAW_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              busy,
   output logic [DIV_W-1:0]  remainder
);

   localparam int DIGIT = sis_pkg::DIGIT_BITS;
   localparam int STEPS = (DRAW_W + DIGIT - 1) / DIGIT;
   localparam int PAD_W = STEPS * DIGIT;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PAD_W-1:0]  shift_ff, shift_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W:0]    trial;
   logic [PAD_W-1:0]  shift_step;
   logic [DIV_W-1:0]  rem_step;

   always_comb begin
      rem_step   = rem_ff;
      shift_step = shift_ff;
      trial      = '0;
      for (int d = 0; d < DIGIT; d++) begin
         trial = {rem_step, shift_step[PAD_W-1]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_step   = trial[DIV_W-1:0];
         shift_step = shift_step << 1;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(STEPS);
         shift_in = PAD_W'(dividend);
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         cnt_in   = cnt_ff - 1'b1;
         busy_in  = (cnt_ff != CNT_W'(1));
         shift_in = shift_step;
         rem_in   = rem_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/sis_index_ram.sv -----
`timescale 1ns / 1ps

module sis_index_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 18
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/shuffle_index_splitter.sv -----
`timescale 1ns / 1ps
// A swap position runs the remainder unit over min(RANDOM_BITS, 32) draw bits, 4 bits a
// cycle, then ST_READ_K, ST_READ_J, ST_WRITE_K and ST_WRITE_J, its strobe registered from
// ST_WRITE_J; the final position of a run strobes from ST_READ_LAST. No new request is taken
// until the block is back in idle. Reset: synchronous; a clear pass sweeps all MAX_RECORDS
// index entries with busy high, and repeats after every 255th run when the epoch tag wraps.
// Results are strobed for one cycle; the receiver cannot stall.

module shuffle_index_splitter #(
   parameter int MAX_RECORDS = sis_pkg::DEF_MAX_RECORDS,
   parameter int RANDOM_BITS = sis_pkg::DEF_RANDOM_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sis_pkg::RAND_W-1:0]          req_random_word,
   output logic                                rsp_valid,
   output logic [sis_pkg::INDEX_OUT_W-1:0]     rsp_record_index,
   output logic [sis_pkg::SUBSET_W-1:0]        rsp_subset,
   output logic                                rsp_run_done,
   input  logic                                csr_write_en,
   input  logic [sis_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sis_pkg::CFG_W-1:0]           csr_data
);

   localparam int AW    = $clog2(MAX_RECORDS);
   localparam int CW    = $clog2(MAX_RECORDS + 1);
   localparam int DW    = (RANDOM_BITS < sis_pkg::RAND_W) ? RANDOM_BITS : sis_pkg::RAND_W;
   localparam int TW    = sis_pkg::EPOCH_W;
   localparam int EW    = TW + AW;
   localparam int FW    = sis_pkg::CFG_W;
   localparam int SW    = ((AW > FW) ? AW : FW) + 2;
   localparam int IDX_W = sis_pkg::INDEX_OUT_W;

   localparam logic [TW-1:0] EPOCH_LAST  = {TW{1'b1}};
   localparam logic [TW-1:0] EPOCH_FIRST = TW'(1);

   sis_pkg::state_type state_ff, state_in;

   logic [FW-1:0]  count_ff, count_in;
   logic [FW-1:0]  first_ff, first_in;
   logic [FW-1:0]  second_ff, second_in;
   logic [FW-1:0]  third_ff, third_in;

   logic [AW-1:0]  pos_ff, pos_in;
   logic [AW-1:0]  j_ff, j_in;
   logic [AW-1:0]  a_ff, a_in;
   logic [AW-1:0]  b_ff, b_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [TW-1:0]  epoch_ff, epoch_in;
   logic [sis_pkg::SUBSET_W-1:0] subset_ff, subset_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [sis_pkg::SUBSET_W-1:0] rsp_subset_ff, rsp_subset_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic [SW-1:0]  count_x, n_x, pos_x, e1, e2, e3;
   logic [CW-1:0]  n_eff;
   logic [CW-1:0]  divisor;
   logic           last_pos;
   logic [sis_pkg::SUBSET_W-1:0] label;

   logic           div_start, div_busy;
   logic [CW-1:0]  div_rem;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [EW-1:0]  wr_data, rd_data;
   logic [AW-1:0]  rd_value_k, rd_value_j;

   function automatic logic [AW-1:0] resolve(input logic [EW-1:0] entry,
                                             input logic [AW-1:0] addr,
                                             input logic [TW-1:0] epoch);
      logic [AW-1:0] value;
      value = entry[AW-1:0];
      if (entry[EW-1:AW] != epoch) begin
         value = addr;
      end
      return value;
   endfunction

   // configuration
   always_comb begin
      count_in  = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      third_in  = third_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            sis_pkg::REG_RECORD_COUNT: count_in  = csr_data;
            sis_pkg::REG_FIRST_SIZE:   first_in  = csr_data;
            sis_pkg::REG_SECOND_SIZE:  second_in = csr_data;
            sis_pkg::REG_THIRD_SIZE:   third_in  = csr_data;
            default: ;
         endcase
      end
   end

   // effective count, final-position test, divisor and label
   always_comb begin
      count_x = SW'(count_ff);
      pos_x   = SW'(pos_ff);
      priority if (count_x == '0) begin
         n_x = SW'(1);
      end else if (count_x > SW'(MAX_RECORDS)) begin
         n_x = SW'(MAX_RECORDS);
      end else begin
         n_x = count_x;
      end
      n_eff    = n_x[CW-1:0];
      last_pos = (pos_x + SW'(1)) >= n_x;
      divisor  = n_eff - CW'(pos_ff);
      e1 = SW'(first_ff);
      e2 = e1 + SW'(second_ff);
      e3 = e2 + SW'(third_ff);
      priority if (pos_x < e1) begin
         label = sis_pkg::SUBSET_FIRST;
      end else if (pos_x < e2) begin
         label = sis_pkg::SUBSET_SECOND;
      end else if (pos_x < e3) begin
         label = sis_pkg::SUBSET_THIRD;
      end else begin
         label = sis_pkg::SUBSET_DROPPED;
      end
   end

   assign rd_value_k = resolve(rd_data, pos_ff, epoch_ff);
   assign rd_value_j = resolve(rd_data, j_ff, epoch_ff);

   sis_mod_unit #(
      .DRAW_W (DW),
      .DIV_W  (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_random_word[DW-1:0]),
      .divisor   (divisor),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   sis_index_ram #(
      .DEPTH  (MAX_RECORDS),
      .ADDR_W (AW),
      .DATA_W (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      clr_in        = clr_ff;
      epoch_in      = epoch_ff;
      subset_in     = subset_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_subset_in = rsp_subset_ff;
      rsp_done_in   = rsp_done_ff;
      div_start     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {epoch_ff, b_in};
      rd_addr       = pos_ff;
      unique case (state_ff)
         sis_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_RECORDS - 1)) begin
               clr_in   = '0;
               state_in = sis_pkg::ST_IDLE;
            end
         end
         sis_pkg::ST_IDLE: begin
            if (start) begin
               subset_in = label;
               if (last_pos) begin
                  state_in = sis_pkg::ST_READ_LAST;
               end else begin
                  div_start = 1'b1;
                  state_in  = sis_pkg::ST_DIVIDE;
               end
            end
         end
         sis_pkg::ST_DIVIDE: begin
            if (!div_busy) begin
               j_in     = pos_ff + div_rem[AW-1:0];
               state_in = sis_pkg::ST_READ_K;
            end
         end
         sis_pkg::ST_READ_K: begin
            state_in = sis_pkg::ST_READ_J;
         end
         sis_pkg::ST_READ_J: begin
            rd_addr  = j_ff;
            a_in     = rd_value_k;
            state_in = sis_pkg::ST_WRITE_K;
         end
         sis_pkg::ST_WRITE_K: begin
            b_in     = rd_value_j;
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = {epoch_ff, b_in};
            state_in = sis_pkg::ST_WRITE_J;
         end
         sis_pkg::ST_WRITE_J: begin
            wr_en         = 1'b1;
            wr_addr       = j_ff;
            wr_data       = {epoch_ff, a_ff};
            rsp_valid_in  = 1'b1;
            rsp_index_in  = IDX_W'(b_ff);
            rsp_subset_in = subset_ff;
            rsp_done_in   = 1'b0;
            pos_in        = pos_ff + 1'b1;
            state_in      = sis_pkg::ST_IDLE;
         end
         sis_pkg::ST_READ_LAST: begin
            // final self-swap: emit entry at position, advance epoch; on wrap, clear the memory first
            rsp_valid_in  = 1'b1;
            rsp_index_in  = IDX_W'(rd_value_k);
            rsp_subset_in = subset_ff;
            rsp_done_in   = 1'b1;
            pos_in        = '0;
            if (epoch_ff == EPOCH_LAST) begin
               epoch_in = EPOCH_FIRST;
               state_in = sis_pkg::ST_CLEAR;
            end else begin
               epoch_in = epoch_ff + 1'b1;
               state_in = sis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sis_pkg::ST_CLEAR;
         count_ff     <= sis_pkg::RESET_RECORD_COUNT;
         first_ff     <= sis_pkg::RESET_FIRST_SIZE;
         second_ff    <= sis_pkg::RESET_SECOND_SIZE;
         third_ff     <= sis_pkg::RESET_THIRD_SIZE;
         pos_ff       <= '0;
         clr_ff       <= '0;
         epoch_ff     <= EPOCH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         third_ff     <= third_in;
         pos_ff       <= pos_in;
         clr_ff       <= clr_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff          <= j_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      subset_ff     <= subset_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_subset_ff <= rsp_subset_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign busy             = (state_ff != sis_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_index = rsp_index_ff;
   assign rsp_subset       = rsp_subset_ff;
   assign rsp_run_done     = rsp_done_ff;

endmodule

// ----- rtl/sis_checker.sv -----
`timescale 1ns / 1ps

module sis_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_run_done
);

   // take a request, go busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   // one strobe per request, never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a result only follows work in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding busy cycle");

   // hold off requests while the memory is swept after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("not busy right after reset");

   // end of run only with a strobe
   assert property (@(posedge clock) disable iff (reset)
      (rsp_run_done && !rsp_valid && $past(rsp_valid)) |-> $stable(rsp_run_done))
      else $error("run_done changed without a result");

endmodule

bind shuffle_index_splitter sis_checker u_sis_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_run_done (rsp_run_done)
);

// ----- sim/shuffle_index_splitter_tb.sv -----
`timescale 1ns / 1ps

module shuffle_index_splitter_tb;

   localparam int MAX_RECORDS = sis_pkg::DEF_MAX_RECORDS;
   localparam int IDX_W       = sis_pkg::INDEX_OUT_W;
   localparam int CFG_W       = sis_pkg::CFG_W;
   localparam int ITEM_TARGET = 1800;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 16;

   typedef struct packed {
      logic [sis_pkg::INDEX_OUT_W-1:0] record_index;
      logic [sis_pkg::SUBSET_W-1:0]    subset;
      logic                            run_done;
   } placement_type;

   typedef struct {
      bit                               is_write;
      logic [sis_pkg::CSR_INDEX_W-1:0]  reg_sel;
      logic [sis_pkg::CFG_W-1:0]        value;
      logic [sis_pkg::RAND_W-1:0]       word;
      bit                               typed;
      placement_type                    want;
   } stim_row_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [sis_pkg::RAND_W-1:0]       req_random_word;
   logic                             rsp_valid;
   logic [sis_pkg::INDEX_OUT_W-1:0]  rsp_record_index;
   logic [sis_pkg::SUBSET_W-1:0]     rsp_subset;
   logic                             rsp_run_done;
   logic                             csr_write_en;
   logic [sis_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [sis_pkg::CFG_W-1:0]        csr_data;

   // shuffle state mirrored from the block
   logic [IDX_W-1:0]        perm_table [MAX_RECORDS];
   bit                      perm_tag [MAX_RECORDS];
   bit                      perm_parity;
   int unsigned             perm_position;
   logic [CFG_W-1:0]        cfg_count;
   logic [CFG_W-1:0]        cfg_first;
   logic [CFG_W-1:0]        cfg_second;
   logic [CFG_W-1:0]        cfg_third;

   placement_type           pending_placements [$];
   stim_row_type            directed_rows [$];

   int unsigned             mismatches;
   int unsigned             items_sent;
   int unsigned             placements_checked;
   int unsigned             runs_completed;
   int unsigned             phases_run;
   int unsigned             idle_cycles;

   shuffle_index_splitter uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_record_index (rsp_record_index),
      .rsp_subset       (rsp_subset),
      .rsp_run_done     (rsp_run_done),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [IDX_W-1:0] table_entry(input int unsigned addr);
      if (perm_tag[addr] == perm_parity) return perm_table[addr];
      return addr[IDX_W-1:0];
   endfunction

   task automatic predict_placement(input logic [sis_pkg::RAND_W-1:0] word,
                                    output placement_type want);
      int unsigned n;
      int unsigned k;
      int unsigned j;
      int unsigned rem;
      int unsigned e1;
      int unsigned e2;
      int unsigned e3;
      logic [IDX_W-1:0] at_k;
      logic [IDX_W-1:0] at_j;
      n = 32'(cfg_count);
      if (n < 1) n = 1;
      if (n > MAX_RECORDS) n = MAX_RECORDS;
      k = perm_position;
      if (k >= n - 1) begin
         if (k >= MAX_RECORDS) k = MAX_RECORDS - 1;
         want.record_index = table_entry(k);
         want.run_done = 1'b1;
      end else begin
         rem = n - k;
         j = k + (word % rem);
         at_k = table_entry(k);
         at_j = table_entry(j);
         perm_table[k] = at_j;
         perm_tag[k] = perm_parity;
         perm_table[j] = at_k;
         perm_tag[j] = perm_parity;
         want.record_index = at_j;
         want.run_done = 1'b0;
      end
      e1 = 32'(cfg_first);
      e2 = e1 + 32'(cfg_second);
      e3 = e2 + 32'(cfg_third);
      if (k < e1) want.subset = sis_pkg::SUBSET_FIRST;
      else if (k < e2) want.subset = sis_pkg::SUBSET_SECOND;
      else if (k < e3) want.subset = sis_pkg::SUBSET_THIRD;
      else want.subset = sis_pkg::SUBSET_DROPPED;
      if (want.run_done) begin
         perm_parity = ~perm_parity;
         foreach (perm_tag[i]) perm_tag[i] = ~perm_parity;
         perm_position = 0;
      end else begin
         perm_position = k + 1;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // hold off until the block is quiet, then write one register
   task automatic write_reg(input logic [sis_pkg::CSR_INDEX_W-1:0] sel,
                            input logic [CFG_W-1:0] value);
      start <= 1'b0;
      while (pending_placements.size() != 0 || busy) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= sel;
      csr_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      unique case (sel)
         sis_pkg::REG_RECORD_COUNT: cfg_count = value;
         sis_pkg::REG_FIRST_SIZE:   cfg_first = value;
         sis_pkg::REG_SECOND_SIZE:  cfg_second = value;
         sis_pkg::REG_THIRD_SIZE:   cfg_third = value;
      endcase
   endtask

   task automatic send_request(input logic [sis_pkg::RAND_W-1:0] word, input int unsigned gap,
                               input bit typed, input placement_type typed_want);
      placement_type want;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_random_word <= word;
      do @(posedge clock); while (busy);
      predict_placement(word, want);
      pending_placements.push_back(typed ? typed_want : want);
      items_sent++;
   endtask

   task automatic add_write(input logic [sis_pkg::CSR_INDEX_W-1:0] sel,
                            input logic [CFG_W-1:0] value);
      stim_row_type row;
      row = '{is_write: 1'b1, reg_sel: sel, value: value, word: '0, typed: 1'b0, want: '0};
      directed_rows.push_back(row);
   endtask

   task automatic add_item(input logic [sis_pkg::RAND_W-1:0] word, input bit typed,
                           input int idx, input logic [sis_pkg::SUBSET_W-1:0] sub,
                           input bit done);
      stim_row_type row;
      row = '{is_write: 1'b0, reg_sel: '0, value: '0, word: word, typed: typed,
              want: '{record_index: idx[IDX_W-1:0], subset: sub, run_done: done}};
      directed_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_valid) begin
         if (pending_placements.size() == 0) begin
            report_mismatch($sformatf("placement with nothing outstanding: index %0d",
                                      rsp_record_index));
         end else begin
            want = pending_placements.pop_front();
            if (rsp_record_index !== want.record_index)
               report_mismatch($sformatf("record_index got %0d, expected %0d",
                                         rsp_record_index, want.record_index));
            if (rsp_subset !== want.subset)
               report_mismatch($sformatf("subset got %0d, expected %0d",
                                         rsp_subset, want.subset));
            if (rsp_run_done !== want.run_done)
               report_mismatch($sformatf("run_done got %0d, expected %0d",
                                         rsp_run_done, want.run_done));
            placements_checked++;
            if (want.run_done) runs_completed++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] timeout: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned n_eff;
      int unsigned burst;
      int unsigned pick;
      int unsigned gap;
      bit no_idle;
      logic [CFG_W-1:0] count_val;
      logic [CFG_W-1:0] size_a;
      logic [CFG_W-1:0] size_b;
      logic [CFG_W-1:0] size_c;
      logic [sis_pkg::RAND_W-1:0] word;

      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_random_word = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      items_sent = 0;
      phases_run = 0;

      cfg_count = sis_pkg::RESET_RECORD_COUNT;
      cfg_first = sis_pkg::RESET_FIRST_SIZE;
      cfg_second = sis_pkg::RESET_SECOND_SIZE;
      cfg_third = sis_pkg::RESET_THIRD_SIZE;
      foreach (perm_table[i]) perm_table[i] = IDX_W'(i);
      foreach (perm_tag[i]) perm_tag[i] = 1'b0;
      perm_parity = 1'b1;
      perm_position = 0;

      add_item(32'h0000_0000, 1'b1, 0, sis_pkg::SUBSET_FIRST, 1'b0);
      add_item(32'hFFFF_FFFF, 1'b0, 0, sis_pkg::SUBSET_FIRST, 1'b0);
      add_write(sis_pkg::REG_RECORD_COUNT, 11'd0);
      add_item(32'h0000_0000, 1'b1, 2, sis_pkg::SUBSET_FIRST, 1'b1);
      add_item(32'hFFFF_FFFF, 1'b1, 0, sis_pkg::SUBSET_FIRST, 1'b1);
      add_write(sis_pkg::REG_RECORD_COUNT, 11'd1);
      add_item(32'h1234_5678, 1'b1, 0, sis_pkg::SUBSET_FIRST, 1'b1);
      add_write(sis_pkg::REG_RECORD_COUNT, 11'd2047);
      add_write(sis_pkg::REG_FIRST_SIZE, 11'd0);
      add_write(sis_pkg::REG_THIRD_SIZE, 11'd2047);
      add_item(32'hFFFF_FFFF, 1'b0, 0, sis_pkg::SUBSET_THIRD, 1'b0);
      add_item(32'h8000_0000, 1'b0, 0, sis_pkg::SUBSET_THIRD, 1'b0);
      add_item(32'h7FFF_FFFF, 1'b0, 0, sis_pkg::SUBSET_THIRD, 1'b0);
      add_write(sis_pkg::REG_RECORD_COUNT, 11'd2);
      add_item(32'h0000_0000, 1'b0, 0, sis_pkg::SUBSET_THIRD, 1'b1);
      add_write(sis_pkg::REG_FIRST_SIZE, 11'd1);
      add_write(sis_pkg::REG_SECOND_SIZE, 11'd1);
      add_write(sis_pkg::REG_THIRD_SIZE, 11'd1);
      add_write(sis_pkg::REG_RECORD_COUNT, 11'd5);
      add_item(32'h0000_0000, 1'b1, 0, sis_pkg::SUBSET_FIRST, 1'b0);
      add_item(32'hFFFF_FFFF, 1'b0, 0, sis_pkg::SUBSET_SECOND, 1'b0);
      add_item(32'h0000_0005, 1'b0, 0, sis_pkg::SUBSET_THIRD, 1'b0);
      add_item(32'hAAAA_AAAA, 1'b0, 0, sis_pkg::SUBSET_DROPPED, 1'b0);
      add_item(32'h5555_5555, 1'b0, 0, sis_pkg::SUBSET_DROPPED, 1'b1);
      add_write(sis_pkg::REG_FIRST_SIZE, 11'd0);
      add_write(sis_pkg::REG_SECOND_SIZE, 11'd2047);
      add_write(sis_pkg::REG_RECORD_COUNT, 11'd3);
      add_item(32'hDEAD_BEEF, 1'b0, 0, sis_pkg::SUBSET_SECOND, 1'b0);
      add_item(32'h0BAD_F00D, 1'b0, 0, sis_pkg::SUBSET_SECOND, 1'b0);
      add_item(32'hCAFE_0001, 1'b0, 0, sis_pkg::SUBSET_SECOND, 1'b1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_write)
            write_reg(directed_rows[r].reg_sel, directed_rows[r].value);
         else
            send_request(directed_rows[r].word, $urandom_range(0, 7),
                         directed_rows[r].typed, directed_rows[r].want);
      end

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 29);
         if (pick < 3) begin
            count_val = CFG_W'($urandom_range(0, 2));
         end else if (pick == 3) begin
            if ($urandom_range(0, 1) != 0) count_val = 11'd1024;
            else count_val = CFG_W'($urandom_range(1025, 2047));
         end else begin
            count_val = CFG_W'($urandom_range(3, 16));
         end
         if (count_val == '0) n_eff = 1;
         else if (32'(count_val) > MAX_RECORDS) n_eff = MAX_RECORDS;
         else n_eff = 32'(count_val);

         case ($urandom_range(0, 5))
            0: begin
               size_a = CFG_W'($urandom);
               size_b = CFG_W'($urandom);
               size_c = CFG_W'($urandom);
            end
            1: begin
               size_a = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd0;
               size_b = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd2047;
               size_c = ($urandom_range(0, 1) != 0) ? 11'd0 : 11'd2047;
            end
            default: begin
               size_a = CFG_W'($urandom_range(0, n_eff));
               size_b = CFG_W'($urandom_range(0, n_eff));
               size_c = CFG_W'($urandom_range(0, n_eff));
            end
         endcase

         write_reg(sis_pkg::REG_FIRST_SIZE, size_a);
         write_reg(sis_pkg::REG_SECOND_SIZE, size_b);
         write_reg(sis_pkg::REG_THIRD_SIZE, size_c);
         write_reg(sis_pkg::REG_RECORD_COUNT, count_val);
         phases_run++;

         if (n_eff > 16) begin
            burst = $urandom_range(20, 80);
         end else begin
            burst = $urandom_range(1, 4) * n_eff;
            if ($urandom_range(0, 3) == 0) burst += $urandom_range(1, n_eff);
         end
         no_idle = ($urandom_range(0, 3) == 0);

         repeat (burst) begin
            case ($urandom_range(0, 7))
               0: word = '0;
               1: word = '1;
               default: word = $urandom;
            endcase
            gap = no_idle ? 0 : $urandom_range(0, 7);
            send_request(word, gap, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d shuffle requests over %0d configurations; %0d placements checked",
               items_sent, phases_run + 1, placements_checked);
      $display("Completed %0d shuffle runs; %0d mismatches", runs_completed, mismatches);
      if (mismatches == 0 && pending_placements.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sis_pkg.sv
rtl/sis_mod_unit.sv
rtl/sis_index_ram.sv
rtl/shuffle_index_splitter.sv
rtl/sis_checker.sv
sim/shuffle_index_splitter_tb.sv
